### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro checks on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### sv/dofs_pkg.sv
package dofs_pkg;

   // Options area bounds
   localparam int unsigned OPTIONS_MAX_BYTES = 312;
   localparam int unsigned COOKIE_BYTES      = 4;
   localparam int unsigned INDEX_W           = 10;
   localparam int unsigned LIMIT_W           = INDEX_W + 1;
   localparam logic [INDEX_W-1:0] INDEX_MAX  = '1;
   localparam logic [1:0] COOKIE_LAST_INDEX  = 2'(COOKIE_BYTES - 1);
   localparam logic [LIMIT_W-1:0] CODE_LIMIT = LIMIT_W'(OPTIONS_MAX_BYTES);

   // Magic cookie, first byte first
   localparam logic [7:0] COOKIE_MAGIC [COOKIE_BYTES] = '{8'd99, 8'd130, 8'd83, 8'd99};

   // Most value bytes the result can hold
   localparam logic [2:0] VALUE_BYTES_MAX = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_TARGET_CODE = 2'd0;
   localparam logic [1:0] CSR_TARGET_LEN  = 2'd1;

   // Register reset values
   localparam logic [7:0] TARGET_CODE_RESET = 8'd53;
   localparam logic [2:0] TARGET_LEN_RESET  = 3'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        cookie_ok;
      logic        found;
      logic [31:0] value;
   } rsp_type;

   typedef struct packed {
      logic [7:0] target_code;
      logic [2:0] target_len;
   } cfg_type;

endpackage

### sv/dofs_csr.sv
module dofs_csr
   import dofs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output cfg_type    cfg
);

   logic [7:0] target_code_ff;
   logic [2:0] target_len_ff;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_code_ff <= TARGET_CODE_RESET;
         target_len_ff  <= TARGET_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_CODE: target_code_ff <= csr_data;
            CSR_TARGET_LEN:  target_len_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign cfg.target_code = target_code_ff;
   assign cfg.target_len  = target_len_ff;

endmodule

### sv/dofs_parser.sv
`include "assert_macros.svh"

module dofs_parser
   import dofs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp_in
);

   typedef enum logic [2:0] {
      PH_COOKIE,
      PH_CODE,
      PH_LEN,
      PH_SKIP,
      PH_CAPTURE,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]         skip_left_ff, skip_left_in;
   logic [2:0]         capture_left_ff, capture_left_in;
   logic [7:0]         held_code_ff, held_code_in;
   logic [31:0]        value_acc_ff, value_acc_in;
   logic               cookie_good_ff, cookie_good_in;
   logic               hit_ff, hit_in;

   logic [2:0]         cap_total;
   logic [1:0]         cap_pos;
   logic               code_past_limit;
   phase_type          code_phase;

   // Value bytes captured on a match
   assign cap_total = (cfg.target_len > VALUE_BYTES_MAX) ? VALUE_BYTES_MAX : cfg.target_len;
   assign cap_pos   = 2'(cap_total - capture_left_ff);

   // Code byte handling, shared by the code phase and the pad-then-code case
   assign code_past_limit = ({1'b0, byte_index_ff} + LIMIT_W'(cfg.target_len)) >= CODE_LIMIT;

   always_comb begin
      if (code_past_limit) begin
         code_phase = PH_DONE;
      end else if (req.data_byte != 8'd0 || cfg.target_code == 8'd0) begin
         code_phase = PH_LEN;
      end else begin
         code_phase = PH_CODE;
      end
   end

   // Next state for the byte at the input
   always_comb begin
      phase_in        = phase_ff;
      skip_left_in    = skip_left_ff;
      capture_left_in = capture_left_ff;
      held_code_in    = held_code_ff;
      value_acc_in    = value_acc_ff;
      cookie_good_in  = cookie_good_ff;
      hit_in          = hit_ff;

      case (phase_ff)
         PH_COOKIE: begin
            if (req.data_byte != COOKIE_MAGIC[byte_index_ff[1:0]]) begin
               cookie_good_in = 1'b0;
               phase_in       = PH_DONE;
            end else if (byte_index_ff[1:0] == COOKIE_LAST_INDEX) begin
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            phase_in = code_phase;
            if (code_phase == PH_LEN) begin
               held_code_in = req.data_byte;
            end
         end
         PH_LEN: begin
            if (held_code_ff == cfg.target_code &&
                req.data_byte == {5'd0, cfg.target_len}) begin
               hit_in          = 1'b1;
               value_acc_in    = '0;
               capture_left_in = cap_total;
               phase_in        = (cap_total != 3'd0) ? PH_CAPTURE : PH_DONE;
            end else if (held_code_ff == 8'd0) begin
               // zero code was a pad; this byte is the next code
               phase_in = code_phase;
               if (code_phase == PH_LEN) begin
                  held_code_in = req.data_byte;
               end
            end else if (req.data_byte == 8'd0) begin
               phase_in = PH_CODE;
            end else begin
               skip_left_in = req.data_byte;
               phase_in     = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_left_in = skip_left_ff - 8'd1;
            if (skip_left_ff == 8'd1) begin
               phase_in = PH_CODE;
            end
         end
         PH_CAPTURE: begin
            value_acc_in    = value_acc_ff | (32'(req.data_byte) << {cap_pos, 3'b000});
            capture_left_in = capture_left_ff - 3'd1;
            if (capture_left_ff == 3'd1) begin
               phase_in = PH_DONE;
            end
         end
         default: ;
      endcase

      byte_index_in = (byte_index_ff != INDEX_MAX) ? byte_index_ff + 1'b1 : byte_index_ff;

      // Result as seen after this byte
      rsp_in.cookie_ok = cookie_good_in && (phase_in != PH_COOKIE);
      rsp_in.found     = hit_in;
      rsp_in.value     = hit_in ? value_acc_in : '1;

      // Last byte starts a fresh area
      if (req.last) begin
         phase_in        = PH_COOKIE;
         byte_index_in   = '0;
         skip_left_in    = '0;
         capture_left_in = '0;
         held_code_in    = '0;
         value_acc_in    = '0;
         cookie_good_in  = 1'b1;
         hit_in          = 1'b0;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_COOKIE;
         byte_index_ff   <= '0;
         skip_left_ff    <= '0;
         capture_left_ff <= '0;
         held_code_ff    <= '0;
         value_acc_ff    <= '0;
         cookie_good_ff  <= 1'b1;
         hit_ff          <= 1'b0;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         byte_index_ff   <= byte_index_in;
         skip_left_ff    <= skip_left_in;
         capture_left_ff <= capture_left_in;
         held_code_ff    <= held_code_in;
         value_acc_ff    <= value_acc_in;
         cookie_good_ff  <= cookie_good_in;
         hit_ff          <= hit_in;
      end
   end

   `ASSERT_NEVER(a_capture_nonzero, clock, reset, phase_ff == PH_CAPTURE && capture_left_ff == 3'd0, "capture phase with no bytes left")
   `ASSERT_NEVER(a_skip_nonzero, clock, reset, phase_ff == PH_SKIP && skip_left_ff == 8'd0, "skip phase with no bytes left")
   `ASSERT_CLK(a_hit_cookie, clock, reset, hit_ff |-> cookie_good_ff && phase_ff != PH_COOKIE, "match recorded without a good cookie")

endmodule

### sv/dhcp_option_field_finder.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_payload: data_byte, last
// rsp     | out       | rsp_valid/rsp_ready | rsp_payload: cookie_ok, found, value
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One byte is taken per cycle while req_ready is high; the parser state updates in the cycle it is taken.
// A result appears in the output register the cycle after its last byte is taken.
// req_ready drops only while a result sits in the output register and rsp_ready is low.
// Synchronous reset returns the parser to cookie check and the registers to 53 and 1.
// csr writes are always ready and take effect on the next byte.
`include "assert_macros.svh"

module dhcp_option_field_finder
   import dofs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type cfg;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    req_accept;

   dofs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dofs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req_payload),
      .cfg        (cfg),
      .rsp_in     (rsp_in)
   );

   // Input flows while the output register is free or draining
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_payload.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_payload.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_CLK(a_last_gives_rsp, clock, reset, req_accept && req_payload.last |=> rsp_valid_ff, "last byte did not produce a result")
   `ASSERT_CLK(a_no_rsp_midarea, clock, reset, req_accept && !req_payload.last && !rsp_valid_ff |=> !rsp_valid_ff, "result without a last byte")
   `ASSERT_CLK(a_not_found_ones, clock, reset, rsp_valid_ff |-> rsp_ff.found || rsp_ff.value == 32'hFFFF_FFFF, "value not all ones when nothing found")
   `ASSERT_NEVER(a_no_overrun, clock, reset, req_accept && rsp_valid_ff && !rsp_ready, "byte taken while result is stalled")

endmodule
